// ===== rtl/srdd_pkg.sv =====
// Shared types, constants and angle tables of the sensor ring direction block.
`default_nettype none
package srdd_pkg;

    localparam int NUM_SENSORS = 16;
    localparam int CNT_W       = 16;
    localparam int DUTY_W      = 16;
    localparam int TRIG_W      = 17;
    localparam int PROD_W      = TRIG_W + DUTY_W - 1 + 1;
    localparam int GROUP       = 4;
    localparam int NUM_GROUPS  = (NUM_SENSORS + GROUP - 1) / GROUP;
    localparam int PART_W      = PROD_W + 2;
    localparam int TOT_W       = PART_W + 2;
    localparam int XW          = 22;
    localparam int UW          = XW - 1;
    localparam int L2W         = 2 * UW;
    localparam int HALF_W      = L2W / 2;
    localparam int DEG_W       = 31;
    localparam int NUM_DEG     = 90;
    localparam int DIV_STEPS   = DUTY_W;
    localparam int ROOT_STEPS  = 32;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [19:0] MILLI_SQ    = 20'd1000000;

    localparam logic [8:0] BASE_Q0 = 9'd0;
    localparam logic [8:0] BASE_Q1 = 9'd90;
    localparam logic [8:0] BASE_Q2 = 9'd180;
    localparam logic [8:0] BASE_Q3 = 9'd270;

    localparam logic [0:0] REG_SAMPLES = 1'd0;
    localparam logic [0:0] REG_ALPHA   = 1'd1;

    localparam logic [15:0] SAMPLES_RESET = 16'd100;
    localparam logic [15:0] ALPHA_RESET   = 16'd19661;

    typedef logic signed [TRIG_W-1:0] q15_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [XW-1:0]     vec_t;
    typedef logic [DEG_W-1:0]         q30_t;
    typedef q15_t sens_tab_t [NUM_SENSORS];
    typedef q30_t deg_tab_t [NUM_DEG];
    typedef logic [63:0] div_tab_t [7];

    localparam div_tab_t TS_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};
    localparam div_tab_t TC_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182};

    typedef struct packed {
        logic sample;
        logic load;
        logic step;
        logic ema_a;
        logic ema_b;
        logic prod;
    } lane_ctl_t;

    typedef struct packed {
        logic stage_a;
        logic stage_b;
        logic stage_c;
    } merge_ctl_t;

    typedef enum logic [3:0] {
        T_IDLE, T_DIV, T_EMA_A, T_EMA_B, T_PROD,
        T_SUM_A, T_SUM_B, T_ROUND, T_POLAR, T_WAIT
    } top_state_t;

    typedef enum logic [2:0] {
        P_IDLE, P_SQUARE, P_SUM, P_SCALE, P_JOIN, P_SQRT, P_DIR, P_DONE
    } polar_state_t;

    // returns {cos, sin} in Q30
    function automatic logic [127:0] quarter_trig(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic signed [63:0] sv;
        logic signed [63:0] cv;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        ts = x;
        tc = Q30_ONE;
        sv = $signed(x);
        cv = $signed(Q30_ONE);
        for (int k = 1; k <= 7; k++) begin
            ts = ((ts * x2) >> 30) / TS_DIV[k-1];
            tc = ((tc * x2) >> 30) / TC_DIV[k-1];
            if (k % 2 == 1) begin
                sv = sv - $signed(ts);
                cv = cv - $signed(tc);
            end else begin
                sv = sv + $signed(ts);
                cv = cv + $signed(tc);
            end
        end
        if (sv < 0) sv = 0;
        if (sv > $signed(Q30_ONE)) sv = $signed(Q30_ONE);
        if (cv < 0) cv = 0;
        if (cv > $signed(Q30_ONE)) cv = $signed(Q30_ONE);
        return {cv, sv};
    endfunction

    function automatic sens_tab_t build_sens(input bit want_sin);
        sens_tab_t    tab;
        logic [63:0]  t;
        logic [1:0]   q;
        logic [127:0] cs;
        logic [63:0]  c;
        logic [63:0]  s;
        q15_t         c15;
        q15_t         s15;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            t = (64'(i) << 32) / NUM_SENSORS;
            q = t[31:30];
            cs = quarter_trig(t & (Q30_ONE - 64'd1));
            c = cs[127:64];
            s = cs[63:0];
            c15 = TRIG_W'((c + 64'd16384) >> 15);
            s15 = TRIG_W'((s + 64'd16384) >> 15);
            case (q)
                2'd0:    tab[i] = want_sin ? s15 : c15;
                2'd1:    tab[i] = want_sin ? c15 : -s15;
                2'd2:    tab[i] = want_sin ? -s15 : -c15;
                default: tab[i] = want_sin ? -c15 : s15;
            endcase
        end
        return tab;
    endfunction

    function automatic deg_tab_t build_deg(input bit want_sin);
        deg_tab_t     tc;
        deg_tab_t     tsn;
        logic [127:0] cs;
        for (int i = 0; i <= 45; i++) begin
            cs = quarter_trig((64'(i) << 30) / 64'd90);
            tc[i]  = DEG_W'(cs[127:64]);
            tsn[i] = DEG_W'(cs[63:0]);
        end
        tsn[45] = tc[45];
        for (int i = 46; i < NUM_DEG; i++) begin
            tc[i]  = tsn[90-i];
            tsn[i] = tc[90-i];
        end
        return want_sin ? tsn : tc;
    endfunction

    localparam sens_tab_t SENS_COS = build_sens(1'b0);
    localparam sens_tab_t SENS_SIN = build_sens(1'b1);
    localparam deg_tab_t  DEG_COS  = build_deg(1'b0);
    localparam deg_tab_t  DEG_SIN  = build_deg(1'b1);

endpackage
`default_nettype wire

// ===== rtl/srdd_lane.sv =====
// One sensor lane: low counter, serial duty divider, smoothing and trig weighting.
`default_nettype none
module srdd_lane (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire srdd_pkg::lane_ctl_t         ctl,
    input  wire logic                        pin_level,
    input  wire logic [srdd_pkg::CNT_W-1:0]  div_value,
    input  wire logic [15:0]                 alpha,
    input  wire srdd_pkg::q15_t              cos_w,
    input  wire srdd_pkg::q15_t              sin_w,
    output srdd_pkg::prod_t                  prod_x,
    output srdd_pkg::prod_t                  prod_y
);
    logic [srdd_pkg::CNT_W-1:0]  low_reg;
    logic [srdd_pkg::CNT_W-1:0]  low_next;
    logic                        first_reg;
    logic [srdd_pkg::CNT_W-1:0]  rem_reg;
    logic [srdd_pkg::DUTY_W-1:0] quo_reg;
    logic [srdd_pkg::CNT_W:0]    rem_dbl;
    logic [31:0]                 p_new_reg;
    logic [32:0]                 p_old_reg;
    logic [33:0]                 mix;
    logic [srdd_pkg::DUTY_W-1:0] duty_reg;
    srdd_pkg::prod_t             px_reg;
    srdd_pkg::prod_t             py_reg;

    assign low_next = low_reg + {{(srdd_pkg::CNT_W-1){1'b0}}, ~pin_level};
    assign rem_dbl  = {rem_reg, 1'b0};
    assign mix      = {2'b00, p_new_reg} + {1'b0, p_old_reg} + 34'd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg   <= '0;
            first_reg <= 1'b1;
        end else begin
            if (ctl.sample) begin
                low_reg <= ctl.load ? '0 : low_next;
            end
            if (ctl.ema_b) begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg <= low_next;
            quo_reg <= '0;
        end else if (ctl.step) begin
            if (rem_dbl >= {1'b0, div_value}) begin
                rem_reg <= srdd_pkg::CNT_W'(rem_dbl - {1'b0, div_value});
                quo_reg <= {quo_reg[srdd_pkg::DUTY_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_dbl[srdd_pkg::CNT_W-1:0];
                quo_reg <= {quo_reg[srdd_pkg::DUTY_W-2:0], 1'b0};
            end
        end
        if (ctl.ema_a) begin
            p_new_reg <= alpha * quo_reg;
            p_old_reg <= (17'd65536 - {1'b0, alpha}) * duty_reg;
        end
        if (ctl.ema_b) begin
            duty_reg <= first_reg ? quo_reg : mix[31:16];
        end
        if (ctl.prod) begin
            px_reg <= srdd_pkg::PROD_W'(cos_w * $signed({1'b0, duty_reg}));
            py_reg <= srdd_pkg::PROD_W'(sin_w * $signed({1'b0, duty_reg}));
        end
    end

    assign prod_x = px_reg;
    assign prod_y = py_reg;
endmodule
`default_nettype wire

// ===== rtl/srdd_merge.sv =====
// Registered adder tree over the lanes and rounding of the vector sums.
`default_nettype none
module srdd_merge (
    input  wire logic                 aclk,
    input  wire srdd_pkg::merge_ctl_t ctl,
    input  wire srdd_pkg::prod_t      prod_x [srdd_pkg::NUM_SENSORS],
    input  wire srdd_pkg::prod_t      prod_y [srdd_pkg::NUM_SENSORS],
    output srdd_pkg::vec_t            vec_x,
    output srdd_pkg::vec_t            vec_y
);
    logic signed [srdd_pkg::PART_W-1:0] part_x_reg [srdd_pkg::NUM_GROUPS];
    logic signed [srdd_pkg::PART_W-1:0] part_y_reg [srdd_pkg::NUM_GROUPS];
    logic signed [srdd_pkg::PART_W-1:0] part_x [srdd_pkg::NUM_GROUPS];
    logic signed [srdd_pkg::PART_W-1:0] part_y [srdd_pkg::NUM_GROUPS];
    logic signed [srdd_pkg::TOT_W-1:0]  tot_x_reg;
    logic signed [srdd_pkg::TOT_W-1:0]  tot_y_reg;
    logic signed [srdd_pkg::TOT_W-1:0]  tot_x;
    logic signed [srdd_pkg::TOT_W-1:0]  tot_y;
    srdd_pkg::vec_t                     x_reg;
    srdd_pkg::vec_t                     y_reg;

    function automatic srdd_pkg::vec_t round_sum(input logic signed [srdd_pkg::TOT_W-1:0] acc);
        logic [srdd_pkg::TOT_W-1:0] mag;
        logic [srdd_pkg::TOT_W-1:0] q;
        mag = acc[srdd_pkg::TOT_W-1] ? -acc : acc;
        q   = (mag + srdd_pkg::TOT_W'(32768)) >> 16;
        return acc[srdd_pkg::TOT_W-1] ? -srdd_pkg::XW'(q) : srdd_pkg::XW'(q);
    endfunction

    always_comb begin
        for (int g = 0; g < srdd_pkg::NUM_GROUPS; g++) begin
            part_x[g] = '0;
            part_y[g] = '0;
            for (int j = 0; j < srdd_pkg::GROUP; j++) begin
                if (g * srdd_pkg::GROUP + j < srdd_pkg::NUM_SENSORS) begin
                    part_x[g] = part_x[g] + srdd_pkg::PART_W'(prod_x[g*srdd_pkg::GROUP+j]);
                    part_y[g] = part_y[g] + srdd_pkg::PART_W'(prod_y[g*srdd_pkg::GROUP+j]);
                end
            end
        end
        tot_x = '0;
        tot_y = '0;
        for (int g = 0; g < srdd_pkg::NUM_GROUPS; g++) begin
            tot_x = tot_x + srdd_pkg::TOT_W'(part_x_reg[g]);
            tot_y = tot_y + srdd_pkg::TOT_W'(part_y_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.stage_a) begin
            part_x_reg <= part_x;
            part_y_reg <= part_y;
        end
        if (ctl.stage_b) begin
            tot_x_reg <= tot_x;
            tot_y_reg <= tot_y;
        end
        if (ctl.stage_c) begin
            x_reg <= round_sum(tot_x_reg);
            y_reg <= round_sum(tot_y_reg);
        end
    end

    assign vec_x = x_reg;
    assign vec_y = y_reg;
endmodule
`default_nettype wire

// ===== rtl/srdd_polar.sv =====
// Vector length by bit-serial square root and direction by degree search.
`default_nettype none
module srdd_polar (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire srdd_pkg::vec_t vec_x,
    input  wire srdd_pkg::vec_t vec_y,
    output logic                done,
    output logic [8:0]          angle_deg,
    output logic [13:0]         magnitude_milli
);
    srdd_pkg::polar_state_t state_reg;
    srdd_pkg::polar_state_t state_next;

    logic [srdd_pkg::UW-1:0]     ax;
    logic [srdd_pkg::UW-1:0]     ay;
    logic [srdd_pkg::UW-1:0]     u_reg;
    logic [srdd_pkg::UW-1:0]     v_reg;
    logic [8:0]                  base_reg;
    logic                        zero_reg;
    logic [srdd_pkg::L2W-1:0]    sqx_reg;
    logic [srdd_pkg::L2W-1:0]    sqy_reg;
    logic [srdd_pkg::L2W:0]      len2_reg;
    logic [srdd_pkg::HALF_W+19:0] plo_reg;
    logic [srdd_pkg::HALF_W+19:0] phi_reg;
    logic [63:0]                 a_reg;
    logic [63:0]                 r_reg;
    logic [4:0]                  k_reg;
    logic [63:0]                 bitv;
    logic [63:0]                 trial;
    logic [63:0]                 r_step;
    logic [6:0]                  d_reg;
    logic [srdd_pkg::UW+srdd_pkg::DEG_W-1:0] lhs;
    logic [srdd_pkg::UW+srdd_pkg::DEG_W-1:0] rhs;
    logic [8:0]                  angle_reg;
    logic [13:0]                 mag_reg;

    assign ax     = vec_x[srdd_pkg::XW-1] ? srdd_pkg::UW'(-vec_x) : srdd_pkg::UW'(vec_x);
    assign ay     = vec_y[srdd_pkg::XW-1] ? srdd_pkg::UW'(-vec_y) : srdd_pkg::UW'(vec_y);
    assign bitv   = 64'd1 << {k_reg, 1'b0};
    assign trial  = r_reg + bitv;
    assign r_step = (a_reg >= trial) ? ((r_reg >> 1) + bitv) : (r_reg >> 1);
    assign lhs    = v_reg * srdd_pkg::DEG_COS[d_reg];
    assign rhs    = u_reg * srdd_pkg::DEG_SIN[d_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srdd_pkg::P_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srdd_pkg::P_IDLE, srdd_pkg::P_DONE: begin
                if (start) state_next = srdd_pkg::P_SQUARE;
            end
            srdd_pkg::P_SQUARE: state_next = srdd_pkg::P_SUM;
            srdd_pkg::P_SUM:    state_next = srdd_pkg::P_SCALE;
            srdd_pkg::P_SCALE:  state_next = srdd_pkg::P_JOIN;
            srdd_pkg::P_JOIN:   state_next = srdd_pkg::P_SQRT;
            srdd_pkg::P_SQRT: begin
                if (k_reg == 5'd0) begin
                    state_next = zero_reg ? srdd_pkg::P_DONE : srdd_pkg::P_DIR;
                end
            end
            srdd_pkg::P_DIR: begin
                if (lhs < rhs || d_reg == 7'(srdd_pkg::NUM_DEG - 1)) begin
                    state_next = srdd_pkg::P_DONE;
                end
            end
            default: state_next = srdd_pkg::P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            srdd_pkg::P_SQUARE: begin
                sqx_reg  <= ax * ax;
                sqy_reg  <= ay * ay;
                zero_reg <= (vec_x == '0) && (vec_y == '0);
                if (!vec_x[srdd_pkg::XW-1] && vec_x != '0 && !vec_y[srdd_pkg::XW-1]) begin
                    base_reg <= srdd_pkg::BASE_Q0;
                    u_reg    <= ax;
                    v_reg    <= ay;
                end else if ((vec_x[srdd_pkg::XW-1] || vec_x == '0) &&
                             !vec_y[srdd_pkg::XW-1] && vec_y != '0) begin
                    base_reg <= srdd_pkg::BASE_Q1;
                    u_reg    <= ay;
                    v_reg    <= ax;
                end else if (vec_x[srdd_pkg::XW-1] &&
                             (vec_y[srdd_pkg::XW-1] || vec_y == '0)) begin
                    base_reg <= srdd_pkg::BASE_Q2;
                    u_reg    <= ax;
                    v_reg    <= ay;
                end else begin
                    base_reg <= srdd_pkg::BASE_Q3;
                    u_reg    <= ay;
                    v_reg    <= ax;
                end
            end
            srdd_pkg::P_SUM: begin
                len2_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            end
            srdd_pkg::P_SCALE: begin
                plo_reg <= len2_reg[srdd_pkg::HALF_W-1:0] * srdd_pkg::MILLI_SQ;
                phi_reg <= srdd_pkg::HALF_W'(len2_reg[srdd_pkg::L2W:srdd_pkg::HALF_W])
                           * srdd_pkg::MILLI_SQ;
            end
            srdd_pkg::P_JOIN: begin
                a_reg <= (64'(phi_reg) << srdd_pkg::HALF_W) + 64'(plo_reg);
                r_reg <= '0;
                k_reg <= 5'(srdd_pkg::ROOT_STEPS - 1);
            end
            srdd_pkg::P_SQRT: begin
                if (a_reg >= trial) a_reg <= a_reg - trial;
                r_reg <= r_step;
                k_reg <= k_reg - 5'd1;
                d_reg <= 7'd1;
                if (k_reg == 5'd0) begin
                    mag_reg <= r_step[28:15];
                    if (zero_reg) angle_reg <= '0;
                end
            end
            srdd_pkg::P_DIR: begin
                d_reg <= d_reg + 7'd1;
                if (lhs < rhs) begin
                    angle_reg <= base_reg + 9'(d_reg - 7'd1);
                end else if (d_reg == 7'(srdd_pkg::NUM_DEG - 1)) begin
                    angle_reg <= base_reg + 9'(d_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign done            = (state_reg == srdd_pkg::P_DONE);
    assign angle_deg       = angle_reg;
    assign magnitude_milli = mag_reg;
endmodule
`default_nettype wire

// ===== rtl/sensor_ring_duty_direction.sv =====
// Top level: sample counting, window sequencing, configuration and result register.
// Usage:
//   Input channel s_valid/s_ready carries one snapshot s_pin_levels per transfer;
//   a low bit counts as an active sample of that sensor. Every
//   samples_per_window transfers (0 acts as 1) close a window and produce one
//   result transfer on m_valid/m_ready with m_angle_deg and m_magnitude_milli.
//   Other transfers produce no result.
//   Snapshots inside a window are taken one per cycle. The transfer that closes
//   a window starts the window math; s_ready stays low until it is done:
//   serial duty division in all lanes, smoothing and weighting, adder tree and
//   rounding, squaring and scaling, a bit-serial square root and a degree
//   search in the polar unit.
//   The result sits in an output register; the next window may be counted while
//   it waits. If the receiver stalls when the next window's math ends, the block
//   holds that result and keeps s_ready low until the register frees.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once.
//   Reset clears all counts, restores register defaults and marks every sensor
//   as in its first window.
`default_nettype none
module sensor_ring_duty_direction (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_pin_levels,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [8:0]       m_angle_deg,
    output logic [13:0]      m_magnitude_milli,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    srdd_pkg::top_state_t state_reg;
    srdd_pkg::top_state_t state_next;

    logic [15:0]                samples_reg;
    logic [15:0]                alpha_reg;
    logic [srdd_pkg::CNT_W-1:0] cnt_reg;
    logic [srdd_pkg::CNT_W-1:0] cnt_next;
    logic [srdd_pkg::CNT_W-1:0] limit;
    logic [srdd_pkg::CNT_W-1:0] div_reg;
    logic [3:0]                 step_reg;
    logic                       accept;
    logic                       window_end;
    srdd_pkg::lane_ctl_t        lane_ctl;
    srdd_pkg::merge_ctl_t       merge_ctl;
    logic                       polar_start;
    logic                       polar_done;
    logic                       out_load;
    srdd_pkg::prod_t            prod_x [srdd_pkg::NUM_SENSORS];
    srdd_pkg::prod_t            prod_y [srdd_pkg::NUM_SENSORS];
    srdd_pkg::vec_t             vec_x;
    srdd_pkg::vec_t             vec_y;
    logic [8:0]                 angle;
    logic [13:0]                mag;
    logic                       m_valid_reg;
    logic [8:0]                 angle_reg;
    logic [13:0]                mag_reg;

    assign s_ready    = (state_reg == srdd_pkg::T_IDLE);
    assign accept     = s_valid && s_ready;
    assign limit      = (samples_reg == '0) ? srdd_pkg::CNT_W'(1) : samples_reg;
    assign cnt_next   = cnt_reg + srdd_pkg::CNT_W'(1);
    assign window_end = (cnt_next >= limit);
    assign out_load   = (state_reg == srdd_pkg::T_WAIT) && polar_done &&
                        (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srdd_pkg::T_IDLE;
            samples_reg <= srdd_pkg::SAMPLES_RESET;
            alpha_reg   <= srdd_pkg::ALPHA_RESET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    srdd_pkg::REG_SAMPLES: samples_reg <= cfg_wdata;
                    srdd_pkg::REG_ALPHA:   alpha_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                cnt_reg <= window_end ? '0 : cnt_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && window_end) begin
            div_reg  <= cnt_next;
            step_reg <= '0;
        end else if (state_reg == srdd_pkg::T_DIV) begin
            step_reg <= step_reg + 4'd1;
        end
        if (out_load) begin
            angle_reg <= angle;
            mag_reg   <= mag;
        end
    end

    always_comb begin
        state_next  = state_reg;
        lane_ctl    = '0;
        merge_ctl   = '0;
        polar_start = 1'b0;
        case (state_reg)
            srdd_pkg::T_IDLE: begin
                lane_ctl.sample = accept;
                lane_ctl.load   = accept && window_end;
                if (accept && window_end) state_next = srdd_pkg::T_DIV;
            end
            srdd_pkg::T_DIV: begin
                lane_ctl.step = 1'b1;
                if (step_reg == 4'(srdd_pkg::DIV_STEPS - 1)) state_next = srdd_pkg::T_EMA_A;
            end
            srdd_pkg::T_EMA_A: begin
                lane_ctl.ema_a = 1'b1;
                state_next     = srdd_pkg::T_EMA_B;
            end
            srdd_pkg::T_EMA_B: begin
                lane_ctl.ema_b = 1'b1;
                state_next     = srdd_pkg::T_PROD;
            end
            srdd_pkg::T_PROD: begin
                lane_ctl.prod = 1'b1;
                state_next    = srdd_pkg::T_SUM_A;
            end
            srdd_pkg::T_SUM_A: begin
                merge_ctl.stage_a = 1'b1;
                state_next        = srdd_pkg::T_SUM_B;
            end
            srdd_pkg::T_SUM_B: begin
                merge_ctl.stage_b = 1'b1;
                state_next        = srdd_pkg::T_ROUND;
            end
            srdd_pkg::T_ROUND: begin
                merge_ctl.stage_c = 1'b1;
                state_next        = srdd_pkg::T_POLAR;
            end
            srdd_pkg::T_POLAR: begin
                polar_start = 1'b1;
                state_next  = srdd_pkg::T_WAIT;
            end
            srdd_pkg::T_WAIT: begin
                if (out_load) state_next = srdd_pkg::T_IDLE;
            end
            default: state_next = srdd_pkg::T_IDLE;
        endcase
    end

    for (genvar i = 0; i < srdd_pkg::NUM_SENSORS; i++) begin : g_lane
        srdd_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (lane_ctl),
            .pin_level (s_pin_levels[i]),
            .div_value (div_reg),
            .alpha     (alpha_reg),
            .cos_w     (srdd_pkg::SENS_COS[i]),
            .sin_w     (srdd_pkg::SENS_SIN[i]),
            .prod_x    (prod_x[i]),
            .prod_y    (prod_y[i])
        );
    end

    srdd_merge u_merge (
        .aclk   (aclk),
        .ctl    (merge_ctl),
        .prod_x (prod_x),
        .prod_y (prod_y),
        .vec_x  (vec_x),
        .vec_y  (vec_y)
    );

    srdd_polar u_polar (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (polar_start),
        .vec_x           (vec_x),
        .vec_y           (vec_y),
        .done            (polar_done),
        .angle_deg       (angle),
        .magnitude_milli (mag)
    );

    assign m_valid           = m_valid_reg;
    assign m_angle_deg       = angle_reg;
    assign m_magnitude_milli = mag_reg;
endmodule
`default_nettype wire
